// ===== hw/rtl/bpn_pkg.sv =====
// Package for the block peak normaliser: sizes, register indexes, constants
// and the divider request/response types. Depends on nothing.
`default_nettype none
package bpn_pkg;
    localparam int MAX_BLOCK_SAMPLES = 65536;
    localparam int ADDR_W            = $clog2(MAX_BLOCK_SAMPLES);
    localparam int LEN_W             = ADDR_W + 1;
    localparam int WINDOW_BLOCKS     = 16;
    localparam int WIN_AW            = $clog2(WINDOW_BLOCKS);
    localparam int FILL_W            = WIN_AW + 1;
    localparam int FADE_BLOCKS       = 8;
    localparam int FADE_W            = 8;
    localparam int GAIN_W            = 17;
    localparam int NUM_W             = 20;
    localparam int PROD_W            = 38;
    localparam int DIV_NW            = 36;
    localparam int DIV_DW            = 20;
    localparam int DIV_CW            = 6;
    localparam int RATIO_NUM         = 32768 * 1000;
    localparam int MILLI             = 1000;

    // Division of a gained product by 1000 as a reciprocal multiplication.
    // A magnitude of 2^25 or more saturates in any case; below that, the
    // magnitude shifted right by three is under 2^22, where multiplying by
    // ceil(2^32 / 1000) and shifting right by 29 gives the exact quotient.
    localparam int          MAG_FIT_W   = 25;
    localparam int          RECIP_SHIFT = 29;
    localparam int          RECIP_W     = 45;
    localparam int          GQ_W        = 17;
    localparam logic [22:0] RECIP_MUL   =
        23'(((64'd1 << 32) + 64'(MILLI) - 64'd1) / 64'(MILLI));

    localparam logic [1:0] REG_SILENCE = 2'd0;
    localparam logic [1:0] REG_LIMIT   = 2'd1;
    localparam logic [1:0] REG_CLAMP   = 2'd2;
    localparam logic [1:0] REG_FADE    = 2'd3;

    typedef struct packed {
        logic              start;
        logic [DIV_NW-1:0] dividend;
        logic [DIV_DW-1:0] divisor;
    } div_req_t;

    typedef struct packed {
        logic              done;
        logic [DIV_NW-1:0] quotient;
    } div_rsp_t;
endpackage
`default_nettype wire

// ===== hw/rtl/bpn_ram.sv =====
// Generic single-write, single-read synchronous RAM with registered read data.
// Depends on nothing.
`default_nettype none
module bpn_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    // Write port and registered read port.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule
`default_nettype wire

// ===== hw/rtl/bpn_div.sv =====
// Restoring unsigned divider, one quotient bit per cycle.
// Depends on bpn_pkg.
`default_nettype none
module bpn_div (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire bpn_pkg::div_req_t req,
    output bpn_pkg::div_rsp_t      rsp
);
    import bpn_pkg::*;

    logic [DIV_NW-1:0] quo_reg, quo_next;
    logic [DIV_DW-1:0] rem_reg, rem_next;
    logic [DIV_DW-1:0] dvs_reg, dvs_next;
    logic [DIV_CW-1:0] cnt_reg, cnt_next;
    logic              run_reg, run_next;
    logic              done_reg, done_next;
    logic [DIV_DW:0]   shifted;
    logic [DIV_DW:0]   diff;

    // One shift-and-subtract step per cycle.
    always_comb
    begin
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        dvs_next  = dvs_reg;
        cnt_next  = cnt_reg;
        run_next  = run_reg;
        done_next = 1'b0;
        shifted   = {rem_reg, quo_reg[DIV_NW-1]};
        diff      = shifted - {1'b0, dvs_reg};
        if (req.start)
        begin
            quo_next = req.dividend;
            rem_next = '0;
            dvs_next = req.divisor;
            cnt_next = DIV_CW'(DIV_NW);
            run_next = 1'b1;
        end
        else if (run_reg)
        begin
            if (!diff[DIV_DW])
            begin
                rem_next = diff[DIV_DW-1:0];
                quo_next = {quo_reg[DIV_NW-2:0], 1'b1};
            end
            else
            begin
                rem_next = shifted[DIV_DW-1:0];
                quo_next = {quo_reg[DIV_NW-2:0], 1'b0};
            end
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == DIV_CW'(1))
            begin
                run_next  = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            run_reg  <= run_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        dvs_reg <= dvs_next;
    end

    assign rsp.done     = done_reg;
    assign rsp.quotient = quo_reg;
endmodule
`default_nettype wire

// ===== hw/rtl/block_peak_normalizer.sv =====
// Top level of the block peak normaliser: sequencer, block store, peak window.
// Depends on bpn_pkg, bpn_ram and bpn_div.
//
// Usage. A request is a transfer when start is high and busy is low; one
// request is handled at a time and busy stays high until it is finished.
// req_type 0 loads sample_in into the block store and gives no result; busy
// stays low after it unless the load carries block_end. Closing a block writes
// its peak into the window and rescans it, with a read state and a compare
// state per held peak. Busy then stays high through the decision on the
// window peak and, for a block that is not silent, through the fade step,
// which boost precedes with the 36-step ratio division.
// req_type 1 drains one sample. Its result is on the result ports for one
// cycle, marked by out_valid, after the sample is read from the store. With
// gain it then passes a multiply, a reciprocal multiply for the division by
// 1000 and a saturation; with fade, a multiply by the fade numerator and the
// 36-step divider by the block length times FADE_BLOCKS, after the gain when
// both are on. Busy falls with the result, so the next drain can follow at
// once. A drain with no block ready answers with status set.
// The receiver cannot stall: each result is taken in the cycle it is shown.
// Configuration writes use cfg_valid/cfg_ready and are meant for idle time.
// Reset clears all control state; the block store and window hold no data
// until written, and no clearing pass is needed.
`default_nettype none
module block_peak_normalizer (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        start,
    output logic             busy,
    input  wire logic        req_type,
    input  wire logic [15:0] sample_in,
    input  wire logic        block_end,
    input  wire logic        boost_request,
    output logic             out_valid,
    output logic [15:0]      sample_out,
    output logic             last_out,
    output logic             silent_flag,
    output logic [15:0]      block_peak,
    output logic [15:0]      boosted_peak,
    output logic             boost_applied,
    output logic             status,
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [15:0] cfg_data
);
    import bpn_pkg::*;

    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_SCAN   = 4'd1;
    localparam logic [3:0] S_SCMP   = 4'd2;
    localparam logic [3:0] S_DECIDE = 4'd3;
    localparam logic [3:0] S_RATIO  = 4'd4;
    localparam logic [3:0] S_FADE   = 4'd5;
    localparam logic [3:0] S_DRD    = 4'd6;
    localparam logic [3:0] S_GMUL   = 4'd7;
    localparam logic [3:0] S_GST    = 4'd8;
    localparam logic [3:0] S_GWT    = 4'd9;
    localparam logic [3:0] S_FNUM   = 4'd10;
    localparam logic [3:0] S_FMUL   = 4'd11;
    localparam logic [3:0] S_FST    = 4'd12;
    localparam logic [3:0] S_FWT    = 4'd13;
    localparam logic [3:0] S_OUT    = 4'd14;

    logic [3:0]        state_reg, state_next;
    logic [15:0]       thr_reg, thr_next;
    logic [15:0]       limit_reg, limit_next;
    logic [15:0]       clamp_reg, clamp_next;
    logic [FADE_W-1:0] fade_rem_reg, fade_rem_next;
    logic [FADE_W-1:0] step_reg, step_next;
    logic [LEN_W-1:0]  len_reg, len_next;
    logic [LEN_W-1:0]  rp_reg, rp_next;
    logic [WIN_AW-1:0] widx_reg, widx_next;
    logic [FILL_W-1:0] fill_reg, fill_next;
    logic [FILL_W-1:0] scan_reg, scan_next;
    logic [15:0]       wmax_reg, wmax_next;
    logic [15:0]       load_peak_reg, load_peak_next;
    logic [15:0]       held_reg, held_next;
    logic [15:0]       run_peak_reg, run_peak_next;
    logic [GAIN_W-1:0] gain_reg, gain_next;
    logic              ready_reg, ready_next;
    logic              silent_reg, silent_next;
    logic              boost_reg, boost_next;
    logic              fade_reg, fade_next;
    logic              boost_req_reg, boost_req_next;
    logic              ov_reg, ov_next;
    logic              status_reg, status_next;
    logic              last_reg, last_next;
    logic [15:0]       so_reg, so_next;
    logic [15:0]       bp_reg, bp_next;
    logic [15:0]       bpk_reg, bpk_next;
    logic              silo_reg, silo_next;
    logic              bapp_reg, bapp_next;
    logic signed [15:0]       t_reg, t_next;
    logic signed [PROD_W-1:0] prod_reg, prod_next;
    logic [NUM_W-1:0]         num_reg, num_next;
    logic [GQ_W-1:0]          gq_reg, gq_next;

    logic              st_we, win_we;
    logic [ADDR_W-1:0] st_waddr;
    logic [15:0]       st_rdata, win_rdata;
    logic [LEN_W-1:0]  len_eff;
    logic [16:0]       abs_in;
    logic [15:0]       peak_new;
    logic [15:0]       m_clamp;
    logic [PROD_W-1:0] mag;
    logic              neg;
    logic [RECIP_W-1:0] recip_prod;
    logic [15:0]       sat_val, sat_abs;
    logic              accept;
    logic              is_last;
    div_req_t          dreq;
    div_rsp_t          drsp;

    bpn_ram #(.WIDTH(16), .DEPTH(MAX_BLOCK_SAMPLES)) u_store (
        .clk   (clk),
        .we    (st_we),
        .waddr (st_waddr),
        .wdata (sample_in),
        .raddr (rp_reg[ADDR_W-1:0]),
        .rdata (st_rdata)
    );

    bpn_ram #(.WIDTH(16), .DEPTH(WINDOW_BLOCKS)) u_window (
        .clk   (clk),
        .we    (win_we),
        .waddr (widx_reg),
        .wdata (peak_new),
        .raddr (scan_reg[WIN_AW-1:0]),
        .rdata (win_rdata)
    );

    bpn_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (dreq),
        .rsp   (drsp)
    );

    assign busy      = (state_reg != S_IDLE);
    assign cfg_ready = 1'b1;
    assign accept    = start && !busy;

    // Load path helpers: effective length, sample magnitude, updated peak.
    always_comb
    begin
        len_eff  = ready_reg ? '0 : len_reg;
        abs_in   = sample_in[15] ? (17'd0 - {1'b0, sample_in}) : {1'b0, sample_in};
        peak_new = load_peak_reg;
        if (len_eff < LEN_W'(MAX_BLOCK_SAMPLES))
        begin
            if (len_eff == '0 || abs_in[15:0] > load_peak_reg)
            begin
                peak_new = abs_in[15:0];
            end
        end
        st_waddr = len_eff[ADDR_W-1:0];
        m_clamp  = (wmax_reg > clamp_reg) ? clamp_reg : wmax_reg;
        if (m_clamp == '0)
        begin
            m_clamp = 16'd1;
        end
        mag        = prod_reg[PROD_W-1] ? (PROD_W'(0) - prod_reg) : prod_reg;
        neg        = prod_reg[PROD_W-1];
        recip_prod = RECIP_W'(mag[MAG_FIT_W-1:3]) * RECIP_W'(RECIP_MUL);
        is_last    = (rp_reg + 1'b1) == len_reg;
    end

    // Saturation of a gained sample and its magnitude.
    always_comb
    begin
        if (!neg)
        begin
            sat_val = (gq_reg > GQ_W'(32767)) ? 16'd32767 : gq_reg[15:0];
            sat_abs = sat_val;
        end
        else
        begin
            sat_abs = (gq_reg > GQ_W'(32768)) ? 16'd32768 : gq_reg[15:0];
            sat_val = 16'd0 - sat_abs;
        end
    end

    // Sequencer.
    always_comb
    begin
        state_next     = state_reg;
        thr_next       = thr_reg;
        limit_next     = limit_reg;
        clamp_next     = clamp_reg;
        fade_rem_next  = fade_rem_reg;
        step_next      = step_reg;
        len_next       = len_reg;
        rp_next        = rp_reg;
        widx_next      = widx_reg;
        fill_next      = fill_reg;
        scan_next      = scan_reg;
        wmax_next      = wmax_reg;
        load_peak_next = load_peak_reg;
        held_next      = held_reg;
        run_peak_next  = run_peak_reg;
        gain_next      = gain_reg;
        ready_next     = ready_reg;
        silent_next    = silent_reg;
        boost_next     = boost_reg;
        fade_next      = fade_reg;
        boost_req_next = boost_req_reg;
        ov_next        = 1'b0;
        status_next    = status_reg;
        last_next      = last_reg;
        so_next        = so_reg;
        bp_next        = bp_reg;
        bpk_next       = bpk_reg;
        silo_next      = silo_reg;
        bapp_next      = bapp_reg;
        t_next         = t_reg;
        prod_next      = prod_reg;
        num_next       = num_reg;
        gq_next        = gq_reg;
        st_we          = 1'b0;
        win_we         = 1'b0;
        dreq.start     = 1'b0;
        dreq.dividend  = mag[DIV_NW-1:0];
        dreq.divisor   = '0;

        // Register writes.
        if (cfg_valid)
        begin
            case (cfg_index)
                REG_SILENCE: thr_next   = cfg_data;
                REG_LIMIT:   limit_next = cfg_data;
                REG_CLAMP:   clamp_next = cfg_data;
                REG_FADE:
                begin
                    fade_rem_next = (cfg_data[7:0] > FADE_W'(FADE_BLOCKS))
                                    ? FADE_W'(FADE_BLOCKS) : cfg_data[7:0];
                end
                default: ;
            endcase
        end

        case (state_reg)
            S_IDLE:
            begin
                if (accept && !req_type)
                begin
                    if (ready_reg)
                    begin
                        ready_next  = 1'b0;
                        silent_next = 1'b0;
                        boost_next  = 1'b0;
                        fade_next   = 1'b0;
                        rp_next     = '0;
                        len_next    = '0;
                    end
                    if (len_eff < LEN_W'(MAX_BLOCK_SAMPLES))
                    begin
                        st_we    = 1'b1;
                        len_next = len_eff + 1'b1;
                    end
                    load_peak_next = peak_new;
                    if (block_end)
                    begin
                        win_we         = 1'b1;
                        widx_next      = widx_reg + 1'b1;
                        if (fill_reg < FILL_W'(WINDOW_BLOCKS))
                        begin
                            fill_next = fill_reg + 1'b1;
                        end
                        held_next      = peak_new;
                        run_peak_next  = peak_new;
                        ready_next     = 1'b1;
                        silent_next    = 1'b0;
                        boost_next     = 1'b0;
                        fade_next      = 1'b0;
                        rp_next        = '0;
                        boost_req_next = boost_request;
                        scan_next      = '0;
                        wmax_next      = '0;
                        state_next     = S_SCAN;
                    end
                end
                else if (accept)
                begin
                    if (!ready_reg || rp_reg >= len_reg
                        || rp_reg >= LEN_W'(MAX_BLOCK_SAMPLES))
                    begin
                        status_next = 1'b1;
                        last_next   = 1'b0;
                        so_next     = '0;
                        bp_next     = '0;
                        bpk_next    = '0;
                        silo_next   = 1'b0;
                        bapp_next   = 1'b0;
                        state_next  = S_OUT;
                    end
                    else
                    begin
                        status_next = 1'b0;
                        state_next  = S_DRD;
                    end
                end
            end
            S_SCAN:
            begin
                state_next = S_SCMP;
            end
            S_SCMP:
            begin
                if (win_rdata > wmax_reg)
                begin
                    wmax_next = win_rdata;
                end
                scan_next  = scan_reg + 1'b1;
                state_next = ((scan_reg + 1'b1) < fill_reg) ? S_SCAN : S_DECIDE;
            end
            S_DECIDE:
            begin
                if (wmax_reg < thr_reg)
                begin
                    silent_next = 1'b1;
                    state_next  = S_IDLE;
                end
                else if (boost_req_reg)
                begin
                    dreq.start    = 1'b1;
                    dreq.dividend = DIV_NW'(RATIO_NUM);
                    dreq.divisor  = DIV_DW'(m_clamp);
                    state_next    = S_RATIO;
                end
                else
                begin
                    state_next = S_FADE;
                end
            end
            S_RATIO:
            begin
                if (drsp.done)
                begin
                    if (drsp.quotient <= DIV_NW'(limit_reg))
                    begin
                        gain_next  = drsp.quotient[GAIN_W-1:0];
                        boost_next = 1'b1;
                    end
                    state_next = S_FADE;
                end
            end
            S_FADE:
            begin
                if (fade_rem_reg != '0)
                begin
                    step_next     = FADE_W'(FADE_BLOCKS) - fade_rem_reg;
                    fade_rem_next = fade_rem_reg - 1'b1;
                    fade_next     = 1'b1;
                end
                state_next = S_IDLE;
            end
            S_DRD:
            begin
                t_next     = $signed(st_rdata);
                state_next = boost_reg ? S_GMUL : (fade_reg ? S_FNUM : S_OUT);
            end
            S_GMUL:
            begin
                prod_next  = PROD_W'(t_reg) * PROD_W'($signed({1'b0, gain_reg}));
                state_next = S_GST;
            end
            S_GST:
            begin
                // Quotient of the magnitude by 1000; large magnitudes saturate.
                gq_next    = (mag[PROD_W-1:MAG_FIT_W] != '0) ? '1
                             : GQ_W'(recip_prod[RECIP_W-1:RECIP_SHIFT]);
                state_next = S_GWT;
            end
            S_GWT:
            begin
                t_next = $signed(sat_val);
                if (sat_abs > run_peak_reg)
                begin
                    run_peak_next = sat_abs;
                end
                state_next = fade_reg ? S_FNUM : S_OUT;
            end
            S_FNUM:
            begin
                num_next   = NUM_W'(step_reg) * NUM_W'(len_reg) + NUM_W'(rp_reg);
                state_next = S_FMUL;
            end
            S_FMUL:
            begin
                prod_next  = PROD_W'(t_reg) * PROD_W'($signed({1'b0, num_reg}));
                state_next = S_FST;
            end
            S_FST:
            begin
                dreq.start   = 1'b1;
                dreq.divisor = DIV_DW'(len_reg * FADE_BLOCKS);
                state_next   = S_FWT;
            end
            S_FWT:
            begin
                if (drsp.done)
                begin
                    t_next     = neg ? $signed(16'd0 - drsp.quotient[15:0])
                                     : $signed(drsp.quotient[15:0]);
                    state_next = S_OUT;
                end
            end
            S_OUT:
            begin
                ov_next    = 1'b1;
                state_next = S_IDLE;
                if (!status_reg)
                begin
                    so_next   = t_reg;
                    last_next = is_last;
                    silo_next = silent_reg;
                    bp_next   = held_reg;
                    bpk_next  = is_last ? run_peak_reg : '0;
                    bapp_next = boost_reg;
                    rp_next   = rp_reg + 1'b1;
                    if (is_last)
                    begin
                        ready_next  = 1'b0;
                        silent_next = 1'b0;
                        boost_next  = 1'b0;
                        fade_next   = 1'b0;
                        len_next    = '0;
                        rp_next     = '0;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control and configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            thr_reg       <= 16'd500;
            limit_reg     <= 16'd10000;
            clamp_reg     <= 16'd30000;
            fade_rem_reg  <= '0;
            step_reg      <= '0;
            len_reg       <= '0;
            rp_reg        <= '0;
            widx_reg      <= '0;
            fill_reg      <= '0;
            scan_reg      <= '0;
            ready_reg     <= 1'b0;
            silent_reg    <= 1'b0;
            boost_reg     <= 1'b0;
            fade_reg      <= 1'b0;
            boost_req_reg <= 1'b0;
            ov_reg        <= 1'b0;
            status_reg    <= 1'b0;
            held_reg      <= '0;
            run_peak_reg  <= '0;
            gain_reg      <= '0;
            load_peak_reg <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            thr_reg       <= thr_next;
            limit_reg     <= limit_next;
            clamp_reg     <= clamp_next;
            fade_rem_reg  <= fade_rem_next;
            step_reg      <= step_next;
            len_reg       <= len_next;
            rp_reg        <= rp_next;
            widx_reg      <= widx_next;
            fill_reg      <= fill_next;
            scan_reg      <= scan_next;
            ready_reg     <= ready_next;
            silent_reg    <= silent_next;
            boost_reg     <= boost_next;
            fade_reg      <= fade_next;
            boost_req_reg <= boost_req_next;
            ov_reg        <= ov_next;
            status_reg    <= status_next;
            held_reg      <= held_next;
            run_peak_reg  <= run_peak_next;
            gain_reg      <= gain_next;
            load_peak_reg <= load_peak_next;
        end
    end

    // Datapath and result registers.
    always_ff @(posedge clk)
    begin
        wmax_reg <= wmax_next;
        t_reg    <= t_next;
        prod_reg <= prod_next;
        num_reg  <= num_next;
        gq_reg   <= gq_next;
        last_reg <= last_next;
        so_reg   <= so_next;
        bp_reg   <= bp_next;
        bpk_reg  <= bpk_next;
        silo_reg <= silo_next;
        bapp_reg <= bapp_next;
    end

    assign out_valid     = ov_reg;
    assign sample_out    = so_reg;
    assign last_out      = last_reg;
    assign silent_flag   = silo_reg;
    assign block_peak    = bp_reg;
    assign boosted_peak  = bpk_reg;
    assign boost_applied = bapp_reg;
    assign status        = status_reg;
endmodule
`default_nettype wire
